// File: rtl/core/csvg_pkg.sv
// Package: types, constants and the cube face table for the cubed-sphere vertex generator.
package csvg_pkg;

  localparam int MAX_SUBDIVISIONS = 255;
  localparam int POS_FRAC_BITS    = 15;

  localparam int DIV_BITS = 17;
  localparam int NUM_W    = 26;
  localparam int C_W      = 18;
  localparam int Q_W      = 16;
  localparam int RES_W    = 70;
  localparam int LEN_W    = 32;

  localparam logic [7:0] N_MAX  = (MAX_SUBDIVISIONS > 255) ? 8'd255 : 8'(MAX_SUBDIVISIONS);
  localparam logic [2:0] FACE_LAST = 3'd5;

  localparam logic signed [C_W-1:0] HALF_ONE = C_W'(32768);
  localparam logic [Q_W-1:0] POS_MAX = 16'h7FFF;

  localparam logic [1:0] AX_ZERO = 2'b00;
  localparam logic [1:0] AX_POS  = 2'b01;
  localparam logic [1:0] AX_NEG  = 2'b11;

  // per face: origin, u axis, v axis
  localparam logic [1:0] FACE_TAB [6][3][3] = '{
    '{'{AX_POS, AX_POS, AX_POS},  '{AX_ZERO, AX_ZERO, AX_NEG}, '{AX_ZERO, AX_NEG, AX_ZERO}},
    '{'{AX_NEG, AX_POS, AX_NEG},  '{AX_ZERO, AX_ZERO, AX_POS}, '{AX_ZERO, AX_NEG, AX_ZERO}},
    '{'{AX_NEG, AX_POS, AX_NEG},  '{AX_POS, AX_ZERO, AX_ZERO}, '{AX_ZERO, AX_ZERO, AX_POS}},
    '{'{AX_NEG, AX_NEG, AX_POS},  '{AX_POS, AX_ZERO, AX_ZERO}, '{AX_ZERO, AX_ZERO, AX_NEG}},
    '{'{AX_NEG, AX_POS, AX_POS},  '{AX_POS, AX_ZERO, AX_ZERO}, '{AX_ZERO, AX_NEG, AX_ZERO}},
    '{'{AX_POS, AX_POS, AX_NEG},  '{AX_NEG, AX_ZERO, AX_ZERO}, '{AX_ZERO, AX_NEG, AX_ZERO}}
  };

  typedef struct packed {
    logic [2:0] face_id;
    logic [7:0] grid_col;
    logic [7:0] grid_row;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [18:0]        vertex_index;
    logic               has_quad;
    logic [18:0]        corner_tl;
    logic [18:0]        corner_tr;
    logic [18:0]        corner_bl;
    logic [18:0]        corner_br;
  } out_item_t;

  typedef struct packed {
    logic [18:0] idx;
    logic        quad;
    logic [8:0]  rows;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [2:0]         face;
    logic [NUM_W-1:0]   den;
    logic [NUM_W-1:0]   rem_u;
    logic [NUM_W-1:0]   rem_v;
    logic [DIV_BITS-1:0] q_u;
    logic [DIV_BITS-1:0] q_v;
  } div_t;

  typedef struct packed {
    side_t               side;
    logic [DIV_BITS-1:0] u;
    logic [DIV_BITS-1:0] v;
    logic [2:0][C_W-1:0] c;
  } cube_t;

  typedef struct packed {
    side_t                 side;
    logic [DIV_BITS-1:0]   u;
    logic [DIV_BITS-1:0]   v;
    logic [2:0]            neg;
    logic [LEN_W-1:0]      len2;
    logic [2:0][RES_W-1:0] res;
    logic [2:0][RES_W-1:0] p;
    logic [2:0][Q_W-1:0]   q;
  } root_t;

  function automatic logic signed [C_W-1:0] scale_term(logic [1:0] s,
                                                       logic signed [C_W-1:0] x);
    logic signed [C_W-1:0] r;
    case (s)
      AX_POS:  r = x;
      AX_NEG:  r = -x;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [C_W-1:0] cube_comp(logic [2:0] face, logic [1:0] k,
                                                      logic [DIV_BITS-1:0] u,
                                                      logic [DIV_BITS-1:0] v);
    logic signed [C_W-1:0] ue;
    logic signed [C_W-1:0] ve;
    ue = $signed({1'b0, u});
    ve = $signed({1'b0, v});
    return scale_term(FACE_TAB[face][0][k], HALF_ONE)
         + scale_term(FACE_TAB[face][1][k], ue)
         + scale_term(FACE_TAB[face][2][k], ve);
  endfunction

endpackage

// File: rtl/core/cubed_sphere_vertex_generator.sv
// Top level: cubed-sphere vertex generator, a chain of cells from grid point to vertex.
// Stages from input accept to output valid: prep, 17 divider cells, cube, length,
// 16 projection cells, output register.
// Throughput: one item per cycle; a cell holds only while every cell after it is full.
// Reset clears all valid bits and sets subdivisions to 1; payload is not reset.
module cubed_sphere_vertex_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  csvg_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output csvg_pkg::out_item_t out_item
);
  import csvg_pkg::*;

  logic [7:0]  n_eff;
  logic [16:0] rows_sq;
  logic [7:0]  cfg_n;
  logic [8:0]  cfg_rows;
  logic [17:0] cfg_sq;

  div_t  div_d [DIV_BITS+1];
  logic  div_v [DIV_BITS+1];
  logic  div_r [DIV_BITS+1];
  cube_t cube_d;
  logic  cube_v;
  logic  cube_r;
  root_t root_d [Q_W+1];
  logic  root_v [Q_W+1];
  logic  root_r [Q_W+1];

  root_t     last;
  out_item_t item_next;
  logic [Q_W-1:0] qk;
  logic [18:0]    idx_b;

  always_comb begin
    cfg_n    = (cfg_wr_data == 8'd0) ? 8'd1 : ((cfg_wr_data > N_MAX) ? N_MAX : cfg_wr_data);
    cfg_rows = {1'b0, cfg_n} + 9'd1;
    cfg_sq   = cfg_rows * cfg_rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff   <= 8'd1;
      rows_sq <= 17'd4;
    end else if (cfg_wr_en) begin
      n_eff   <= cfg_n;
      rows_sq <= cfg_sq[16:0];
    end
  end

  csvg_prep u_prep (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .n_eff(n_eff), .rows_sq(rows_sq),
    .out_valid(div_v[0]), .out_ready(div_r[0]), .out_data(div_d[0])
  );

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    csvg_div_cell #(.BIT(DIV_BITS - 1 - g)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(div_v[g]), .in_ready(div_r[g]), .in_data(div_d[g]),
      .out_valid(div_v[g+1]), .out_ready(div_r[g+1]), .out_data(div_d[g+1])
    );
  end

  csvg_cube u_cube (
    .clk(clk), .rst(rst),
    .in_valid(div_v[DIV_BITS]), .in_ready(div_r[DIV_BITS]), .in_data(div_d[DIV_BITS]),
    .out_valid(cube_v), .out_ready(cube_r), .out_data(cube_d)
  );

  csvg_root_init u_root_init (
    .clk(clk), .rst(rst),
    .in_valid(cube_v), .in_ready(cube_r), .in_data(cube_d),
    .out_valid(root_v[0]), .out_ready(root_r[0]), .out_data(root_d[0])
  );

  for (genvar g = 0; g < Q_W; g++) begin : g_root
    csvg_root_cell #(.BIT(Q_W - 1 - g)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(root_v[g]), .in_ready(root_r[g]), .in_data(root_d[g]),
      .out_valid(root_v[g+1]), .out_ready(root_r[g+1]), .out_data(root_d[g+1])
    );
  end

  assign root_r[Q_W] = !out_valid || out_ready;
  assign last        = root_d[Q_W];

  always_comb begin
    item_next = '0;
    for (int k = 0; k < 3; k++) begin
      qk = last.q[k];
      if (last.neg[k]) begin
        qk = -qk;
      end else if (qk[Q_W-1]) begin
        qk = POS_MAX;
      end
      case (k)
        0:       item_next.pos_x = $signed(qk);
        1:       item_next.pos_y = $signed(qk);
        default: item_next.pos_z = $signed(qk);
      endcase
    end
    idx_b                  = last.side.idx + 19'(last.side.rows);
    item_next.tex_u        = last.u;
    item_next.tex_v        = last.v;
    item_next.vertex_index = last.side.idx;
    item_next.has_quad     = last.side.quad;
    if (last.side.quad) begin
      item_next.corner_tl = last.side.idx;
      item_next.corner_tr = last.side.idx + 19'd1;
      item_next.corner_bl = idx_b;
      item_next.corner_br = idx_b + 19'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (root_r[Q_W]) begin
      out_valid <= root_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (root_r[Q_W]) begin
      out_item <= item_next;
    end
  end

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output not blocked");

  a_no_quad_zero_corners: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.has_quad) |->
      (out_item.corner_tl == 19'd0 && out_item.corner_tr == 19'd0 &&
       out_item.corner_bl == 19'd0 && out_item.corner_br == 19'd0))
    else $error("corners set on item without quad");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.tex_u <= 17'd65536 && out_item.tex_v <= 17'd65536))
    else $error("texture coordinate above one");

  a_quad_corners: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.has_quad) |->
      (out_item.corner_tl == out_item.vertex_index &&
       out_item.corner_tr == out_item.corner_tl + 19'd1 &&
       out_item.corner_br == out_item.corner_bl + 19'd1))
    else $error("quad corners inconsistent");

endmodule

// File: rtl/core/csvg_prep.sv
// Input cell: clamps the grid point, forms the vertex indices and the division operands.
module csvg_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  csvg_pkg::in_item_t in_item,
  input  logic [7:0]         n_eff,
  input  logic [16:0]        rows_sq,
  output logic               out_valid,
  input  logic               out_ready,
  output csvg_pkg::div_t     out_data
);
  import csvg_pkg::*;

  logic [2:0]  face_c;
  logic [7:0]  i_c;
  logic [7:0]  j_c;
  logic [8:0]  rows;
  logic [19:0] idx_full;
  div_t        data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    face_c = (in_item.face_id > FACE_LAST) ? FACE_LAST : in_item.face_id;
    i_c    = (in_item.grid_col > n_eff) ? n_eff : in_item.grid_col;
    j_c    = (in_item.grid_row > n_eff) ? n_eff : in_item.grid_row;
    rows   = {1'b0, n_eff} + 9'd1;
    idx_full = 20'(face_c) * 20'(rows_sq) + 20'(j_c) * 20'(rows) + 20'(i_c);
    data_next.side.idx  = idx_full[18:0];
    data_next.side.quad = (i_c < n_eff) && (j_c < n_eff);
    data_next.side.rows = rows;
    data_next.face  = face_c;
    data_next.den   = NUM_W'({n_eff, 1'b0});
    data_next.rem_u = NUM_W'({i_c, 17'b0}) + NUM_W'(n_eff);
    data_next.rem_v = NUM_W'({j_c, 17'b0}) + NUM_W'(n_eff);
    data_next.q_u   = '0;
    data_next.q_v   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/csvg_div_cell.sv
// Divider cell: settles one quotient bit of u and of v.
module csvg_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  csvg_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output csvg_pkg::div_t out_data
);
  import csvg_pkg::*;

  logic [NUM_W-1:0] trial;
  div_t             data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    trial     = in_data.den << BIT;
    data_next = in_data;
    if (in_data.rem_u >= trial) begin
      data_next.rem_u    = in_data.rem_u - trial;
      data_next.q_u[BIT] = 1'b1;
    end
    if (in_data.rem_v >= trial) begin
      data_next.rem_v    = in_data.rem_v - trial;
      data_next.q_v[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/csvg_cube.sv
// Cube cell: places u and v on the cube face.
module csvg_cube (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  csvg_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output csvg_pkg::cube_t out_data
);
  import csvg_pkg::*;

  cube_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.side = in_data.side;
    data_next.u    = in_data.q_u;
    data_next.v    = in_data.q_v;
    for (int k = 0; k < 3; k++) begin
      data_next.c[k] = cube_comp(in_data.face, 2'(k), in_data.q_u, in_data.q_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/csvg_root_init.sv
// Length cell: squares the components and seeds the projection search.
module csvg_root_init (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  csvg_pkg::cube_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output csvg_pkg::root_t out_data
);
  import csvg_pkg::*;

  logic [2:0][Q_W-1:0]     mag;
  logic [2:0][2*Q_W-1:0]   sq;
  logic [LEN_W-1:0]        len2;
  logic signed [C_W-1:0]   cs;
  root_t                   data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    len2 = '0;
    for (int k = 0; k < 3; k++) begin
      cs     = $signed(in_data.c[k]);
      mag[k] = cs[C_W-1] ? Q_W'(-cs) : Q_W'(cs);
      sq[k]  = mag[k] * mag[k];
      len2   = len2 + LEN_W'(sq[k]);
    end
    data_next.side = in_data.side;
    data_next.u    = in_data.u;
    data_next.v    = in_data.v;
    data_next.len2 = len2;
    for (int k = 0; k < 3; k++) begin
      cs                = $signed(in_data.c[k]);
      data_next.neg[k]  = cs[C_W-1];
      data_next.res[k]  = (RES_W'(sq[k]) << (2 * POS_FRAC_BITS + 2)) - RES_W'(len2);
      data_next.p[k]    = -RES_W'(len2);
      data_next.q[k]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: rtl/core/csvg_root_cell.sv
// Projection cell: settles one bit of each rounded sphere component.
module csvg_root_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  csvg_pkg::root_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output csvg_pkg::root_t out_data
);
  import csvg_pkg::*;

  logic signed [RES_W-1:0] len_s;
  logic signed [RES_W-1:0] trial;
  root_t                   data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next = in_data;
    len_s     = $signed(RES_W'(in_data.len2));
    for (int k = 0; k < 3; k++) begin
      trial = $signed(in_data.res[k]) - ($signed(in_data.p[k]) <<< (BIT + 2))
            - (len_s <<< (2 * BIT + 2));
      if (!trial[RES_W-1]) begin
        data_next.res[k]    = trial;
        data_next.p[k]      = $signed(in_data.p[k]) + (len_s <<< (BIT + 1));
        data_next.q[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule
